// ----- rtl/core/assert_macros.svh -----
// assertion macros for the rtl files that check themselves
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fls assertion failed");

// next-cycle implication, checked outside reset
`define FLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fls assertion failed");

`endif

// ----- rtl/core/fls_pkg.sv -----
// shared types, constants and codes of the free list slot pool
// no dependencies; imported by the top level and fls_stack
package fls_pkg;

    localparam int POOL_SLOTS  = 256;
    localparam int SLOT_W      = $clog2(POOL_SLOTS);
    localparam int CNT_W       = $clog2(POOL_SLOTS + 1);
    localparam int STAT_W      = 32;
    localparam int RESET_SLOTS = (64 < POOL_SLOTS) ? 64 : POOL_SLOTS;
    localparam int DFLT_INIT   = 64;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SLOTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_STEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT    = 2'd3;

    // commands
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // result status
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_DROP   = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] slot_in;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot_out;
        logic [8:0]  free_slots;
        logic [8:0]  capacity;
        logic [8:0]  peak_in_use;
        logic [31:0] alloc_total;
        logic [31:0] free_total;
        logic [31:0] drop_total;
        logic [31:0] grow_total;
    } t_result;

    // stack memory access for one cycle
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [SLOT_W-1:0] wr_data;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              clr;
    } t_stk_req;

endpackage

// ----- rtl/core/free_list_slot_pool_top.sv -----
// top level of the free list slot pool: command sequencer, statistics, config
// depends on fls_pkg, fls_stack and assert_macros.svh
//
// Each command (allocate, free, init, no-op) is taken when start is high and
// busy is low; its single result word appears on o_result for exactly one cycle
// with o_done high, in the cycle after the command is taken unless an allocation
// grows the pool, and busy drops again in the cycle after that, so a new command
// is taken only once the last result is out. An allocation that finds the stack
// empty in grow mode first writes the new indices into the stack ram, one per
// cycle through its single write port, before its result word. The receiver
// cannot stall: o_done is a one-cycle strobe. Configuration writes take effect at
// once and belong in idle periods; reset restores the pool to 64 enabled, free slots.
`include "assert_macros.svh"

module free_list_slot_pool_top
    import fls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd_item             i_item,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GROW = 2'd1;
    localparam logic [1:0] ST_RES  = 2'd2;

    // configuration
    logic             r_mode;
    logic [CNT_W-1:0] r_init_cfg;
    logic [CNT_W-1:0] r_grow_step;
    logic [CNT_W-1:0] r_limit;

    // control and pool state
    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_depth, n_depth;
    logic [CNT_W-1:0]  r_enabled, n_enabled;
    logic [CNT_W-1:0]  r_peak, n_peak;
    logic [STAT_W-1:0] r_alloc, n_alloc;
    logic [STAT_W-1:0] r_free, n_free;
    logic [STAT_W-1:0] r_drop, n_drop;
    logic [STAT_W-1:0] r_grow, n_grow;

    // result payload and growth bookkeeping
    logic [1:0]        r_status, n_status;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_from_ram, n_from_ram;
    logic [SLOT_W-1:0] r_gi, n_gi;
    logic [CNT_W-1:0]  r_gn, n_gn;
    logic [CNT_W-1:0]  r_gbase, n_gbase;

    logic              w_accept;
    logic [CNT_W-1:0]  w_init;
    logic [CNT_W-1:0]  w_limit;
    logic [CNT_W-1:0]  w_room;
    logic [CNT_W-1:0]  w_batch;
    logic              w_can_grow;
    logic [CNT_W-1:0]  w_used;
    t_stk_req          w_req;
    logic [SLOT_W-1:0] w_stk_q;

    assign w_accept = start && !busy;

    // effective init count and capacity ceiling
    always_comb begin
        w_init = (r_init_cfg == '0) ? CNT_W'(DFLT_INIT) : r_init_cfg;
        if (w_init > CNT_W'(POOL_SLOTS)) begin
            w_init = CNT_W'(POOL_SLOTS);
        end
        w_limit = r_limit;
        if (r_limit == '0 || r_limit < w_init || r_limit > CNT_W'(POOL_SLOTS)) begin
            w_limit = CNT_W'(POOL_SLOTS);
        end
    end

    assign w_room     = w_limit - r_enabled;
    assign w_batch    = (w_room > r_grow_step) ? r_grow_step : w_room;
    assign w_can_grow = r_mode && (r_grow_step != '0) && (r_enabled < w_limit);

    always_comb begin
        n_state    = r_state;
        n_depth    = r_depth;
        n_enabled  = r_enabled;
        n_peak     = r_peak;
        n_alloc    = r_alloc;
        n_free     = r_free;
        n_drop     = r_drop;
        n_grow     = r_grow;
        n_status   = r_status;
        n_slot     = r_slot;
        n_from_ram = r_from_ram;
        n_gi       = r_gi;
        n_gn       = r_gn;
        n_gbase    = r_gbase;
        w_used     = '0;
        w_req      = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state    = ST_RES;
                    n_status   = STATUS_OK;
                    n_slot     = '0;
                    n_from_ram = 1'b0;
                    case (i_item.cmd)
                        CMD_ALLOC: begin
                            if (r_depth != '0) begin
                                w_req.rd_en   = 1'b1;
                                w_req.rd_addr = SLOT_W'(r_depth - 1'b1);
                                n_depth       = r_depth - 1'b1;
                                n_alloc       = r_alloc + 1'b1;
                                n_from_ram    = 1'b1;
                                w_used        = r_enabled - n_depth;
                                if (w_used > r_peak) begin
                                    n_peak = w_used;
                                end
                            end else if (w_can_grow) begin
                                n_state = ST_GROW;
                                n_gi    = '0;
                                n_gn    = w_batch;
                                n_gbase = r_enabled;
                            end else begin
                                n_drop   = r_drop + 1'b1;
                                n_status = STATUS_DROP;
                            end
                        end
                        CMD_FREE: begin
                            if (r_depth >= r_enabled) begin
                                n_status = STATUS_REJECT;
                            end else begin
                                w_req.wr_en   = 1'b1;
                                w_req.wr_addr = SLOT_W'(r_depth);
                                w_req.wr_data = i_item.slot_in;
                                n_depth       = r_depth + 1'b1;
                                n_free        = r_free + 1'b1;
                            end
                        end
                        CMD_INIT: begin
                            w_req.clr = 1'b1;
                            n_depth   = w_init;
                            n_enabled = w_init;
                            n_peak    = '0;
                            n_alloc   = '0;
                            n_free    = '0;
                            n_drop    = '0;
                            n_grow    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_GROW: begin
                // new indices go to the bottom of the empty stack in ascending order
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_gi;
                w_req.wr_data = SLOT_W'(r_gbase) + r_gi;
                n_gi          = r_gi + 1'b1;
                if (CNT_W'(r_gi) == r_gn - 1'b1) begin
                    // the pop takes the last index written, no read needed
                    n_state   = ST_RES;
                    n_depth   = r_gn - 1'b1;
                    n_enabled = r_gbase + r_gn;
                    n_grow    = r_grow + STAT_W'(r_gn);
                    n_alloc   = r_alloc + 1'b1;
                    n_slot    = SLOT_W'(r_gbase + r_gn - 1'b1);
                    w_used    = r_gbase + 1'b1;
                    if (w_used > r_peak) begin
                        n_peak = w_used;
                    end
                end
            end
            ST_RES: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_depth   <= CNT_W'(RESET_SLOTS);
            r_enabled <= CNT_W'(RESET_SLOTS);
            r_peak    <= '0;
            r_alloc   <= '0;
            r_free    <= '0;
            r_drop    <= '0;
            r_grow    <= '0;
        end else begin
            r_state   <= n_state;
            r_depth   <= n_depth;
            r_enabled <= n_enabled;
            r_peak    <= n_peak;
            r_alloc   <= n_alloc;
            r_free    <= n_free;
            r_drop    <= n_drop;
            r_grow    <= n_grow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_from_ram <= n_from_ram;
        r_gi       <= n_gi;
        r_gn       <= n_gn;
        r_gbase    <= n_gbase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_init_cfg  <= CNT_W'(DFLT_INIT);
            r_grow_step <= '0;
            r_limit     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POOL_MODE:     r_mode      <= i_cfg_data[0];
                CFG_INITIAL_SLOTS: r_init_cfg  <= i_cfg_data;
                CFG_GROW_STEP:     r_grow_step <= i_cfg_data;
                CFG_SLOT_LIMIT:    r_limit     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fls_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_q     (w_stk_q)
    );

    assign busy   = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_RES);

    always_comb begin
        o_result.status      = r_status;
        o_result.slot_out    = r_from_ram ? w_stk_q : r_slot;
        o_result.free_slots  = r_depth;
        o_result.capacity    = r_enabled;
        o_result.peak_in_use = r_peak;
        o_result.alloc_total = r_alloc;
        o_result.free_total  = r_free;
        o_result.drop_total  = r_drop;
        o_result.grow_total  = r_grow;
    end

    `FLS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy)
    `FLS_ASSERT_NEXT(a_one_word, i_clk, i_rst_n, o_done, !o_done)
    `FLS_ASSERT_NOW(a_depth_le_cap, i_clk, i_rst_n, 1'b1, r_depth <= r_enabled)
    `FLS_ASSERT_NOW(a_cap_le_pool, i_clk, i_rst_n, 1'b1, r_enabled <= CNT_W'(POOL_SLOTS))
    `FLS_ASSERT_NOW(a_drop_slot0, i_clk, i_rst_n, o_done && r_status != STATUS_OK,
                    o_result.slot_out == '0)

endmodule

// ----- rtl/core/fls_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module fls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/fls_stack.sv -----
// free index stack storage: ram plus per-entry written bits
// depends on fls_pkg and fls_ram; an entry not written since init reads as its own index
module fls_stack
    import fls_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stk_req          i_req,
    output logic [SLOT_W-1:0] o_q
);

    logic [POOL_SLOTS-1:0] r_written;
    logic [SLOT_W-1:0]     r_rd_addr;
    logic                  r_rd_hit;
    logic [SLOT_W-1:0]     w_ram_q;

    fls_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (POOL_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_waddr (i_req.wr_addr),
        .i_wdata (i_req.wr_data),
        .i_re    (i_req.rd_en),
        .i_raddr (i_req.rd_addr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_req.clr) begin
            r_written <= '0;
        end else if (i_req.wr_en) begin
            r_written[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_addr <= i_req.rd_addr;
            r_rd_hit  <= r_written[i_req.rd_addr];
        end
    end

    // entries unwritten since the last init read as their own index, not from the ram
    assign o_q = r_rd_hit ? w_ram_q : r_rd_addr;

endmodule
